// ----- rtl/core/aolvs_pkg.sv -----
package aolvs_pkg;

    // Log depth and derived widths
    localparam int RECORDS = 128;
    localparam int IDX_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CNT_W   = $clog2(RECORDS + 1);

    localparam int OP_W    = 2;
    localparam int LABEL_W = 8;
    localparam int VALUE_W = 32;
    localparam int REC_W   = LABEL_W + VALUE_W;

    // Command codes
    localparam logic [OP_W-1:0] OP_SAVE   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [REC_W-1:0]   rec_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

endpackage

// ----- rtl/core/append_only_label_value_store_unit.sv -----
// Append-only label/value store. A command is taken when start is high and
// busy is low. Save and erase finish in the cycle they are taken: the result
// strobe (done) shows on the next cycle and busy never rises, so commands of
// these kinds can be issued back to back. A lookup walks the log from the
// newest record toward the oldest through the single registered read port of
// the record memory, one entry per cycle, and stops at the first label match.
// It stops after the oldest entry if none matches; busy stays high for the
// whole scan (at most RECORDS = 128 entries held); a lookup into an empty log
// answers like a save. The done strobe lasts exactly one cycle and the result
// ports (status, found, value_out) are valid only with it; there is no way to
// hold a result off, so the receiver must take every transfer as it comes.
// The record memory has no reset; reset clears the record count, which empties the log.
module append_only_label_value_store_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  aolvs_pkg::op_t         op,
    input  aolvs_pkg::label_t      label,
    input  aolvs_pkg::value_t      value_in,
    output logic                   done,
    output logic                   status,
    output logic                   found,
    output aolvs_pkg::value_t      value_out
);
    import aolvs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Record memory, no reset
    rec_t   mem [RECORDS];
    rec_t   rd_data_reg;

    logic   state_reg, state_next;
    cnt_t   count_reg, count_next;
    idx_t   ptr_reg, ptr_next;
    label_t key_reg, key_next;
    logic   iss_reg, iss_next;       // read issue in progress
    logic   rd_vld_reg, rd_vld_next; // rd_data_reg holds a scanned entry
    logic   rd_last_reg, rd_last_next; // that entry is the oldest one

    logic   done_reg, done_next;
    logic   status_reg, status_next;
    logic   found_reg, found_next;
    value_t value_reg, value_next;

    logic   accept;
    logic   full;
    logic   wr_en;
    logic   hit;

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (count_reg == cnt_t'(RECORDS));
    assign wr_en  = accept && (op == OP_SAVE) && !full;
    assign hit    = (rd_data_reg[REC_W-1:VALUE_W] == key_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        key_next     = key_reg;
        iss_next     = iss_reg;
        rd_vld_next  = 1'b0;
        rd_last_next = rd_last_reg;
        done_next    = 1'b0;
        status_next  = 1'b0;
        found_next   = 1'b0;
        value_next   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_SAVE:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + cnt_t'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                key_next   = label;
                                ptr_next   = idx_t'(count_reg - cnt_t'(1));
                                iss_next   = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ERASE:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue side: one read a cycle, newest first
                if (iss_reg)
                begin
                    rd_vld_next  = 1'b1;
                    rd_last_next = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - idx_t'(1);
                    end
                end
                // check side: first match going backward is the newest one
                if (rd_vld_reg && (hit || rd_last_reg))
                begin
                    done_next   = 1'b1;
                    found_next  = hit;
                    value_next  = hit ? rd_data_reg[VALUE_W-1:0] : '0;
                    iss_next    = 1'b0;
                    rd_vld_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                iss_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            iss_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            iss_reg    <= iss_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        key_reg     <= key_next;
        rd_last_reg <= rd_last_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        value_reg   <= value_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {label, value_in};
        end
        rd_data_reg <= mem[ptr_reg];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign value_out = value_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(RECORDS))
        else $error("record count above depth");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_found_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (found || status) |-> done)
        else $error("result flag without strobe");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_SAVE && full) |=> (done && status && !found))
        else $error("save into full log not rejected");

    a_lookup_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_LOOKUP) |=> (busy || done))
        else $error("lookup dropped");

endmodule
